FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the waveform generator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mswg_pkg.sv
// ----------------------------------------------------------------------------
// Waveform generator package
// Shape codes and default sizes shared by the generator and its checker.
// ----------------------------------------------------------------------------
package mswg_pkg;

  // Fixed port widths.
  localparam int PhaseW = 32;
  localparam int AmpW   = 16;
  localparam int ShapeW = 3;

  // Default configuration of the generator.
  localparam int PHASE_FRAC_BITS_DEF  = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  // pi/2 in Q1.30, the argument scale of the sine series.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Waveform shape codes.
  typedef enum logic [ShapeW-1:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_SQUARE   = 3'd1,
    SHAPE_TRIANGLE = 3'd2,
    SHAPE_SAW      = 3'd3,
    SHAPE_MOOGSAW  = 3'd4,
    SHAPE_MOOG     = 3'd5,
    SHAPE_EXP      = 3'd6,
    SHAPE_EXPN     = 3'd7
  } wave_shape_e;

endpackage

FILE: sv/multi_shape_waveform_generator_core.sv
// ----------------------------------------------------------------------------
// Multi-shape waveform generator core
// Pipeline: a phase request passes through the input register (x_q) and then the result register (amp_q).
// Throughput: one request per cycle while out_ready_i keeps the result register draining.
// Reset: valids clear and wave_shape returns to sine; sine table is constant logic.
// ----------------------------------------------------------------------------
module multi_shape_waveform_generator_core #(
  parameter int PHASE_FRAC_BITS  = mswg_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = mswg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [mswg_pkg::ShapeW-1:0]         cfg_data_i,
  // Phase request channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mswg_pkg::PhaseW-1:0]  phase_i,
  // Amplitude request channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mswg_pkg::AmpW-1:0]    amplitude_o
);
  import mswg_pkg::*;

  localparam int IdxW  = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int ProdW = 30 + IdxW;
  localparam int AddrW = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [60:0] Q8Bias = 61'(1) << 41;
  localparam logic [60:0] Q4Bias = 61'(1) << 42;

  // Saturate a 20-bit signed Q5.15 value to 16-bit Q1.15.
  function automatic logic signed [AmpW-1:0] sat16(input logic signed [19:0] v);
    logic signed [AmpW-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[AmpW-1:0];
    end
    return r;
  endfunction

  // Configuration register.
  wave_shape_e wave_shape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q <= SHAPE_SINE;
    end else if (cfg_we_i) begin
      wave_shape_q <= wave_shape_e'(cfg_data_i);
    end
  end

  // Align the positive fraction of the phase to Q0.30.
  logic [29:0] x_d;

  if (PHASE_FRAC_BITS >= 30) begin : g_frac_trunc
    assign x_d = phase_i[PHASE_FRAC_BITS-1 -: 30];
  end else begin : g_frac_shift
    assign x_d = {phase_i[PHASE_FRAC_BITS-1:0], {(30 - PHASE_FRAC_BITS){1'b0}}};
  end

  // Pipeline handshake: stage one moves on whenever the result register frees up.
  logic        s1_valid_q;
  logic [29:0] x_q;
  logic        out_valid_q;
  logic signed [AmpW-1:0] amp_q;
  logic        s1_advance;

  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q <= x_d;
    end
  end

  // Quarter-wave sine table, built at elaboration from the Q1.30 series.
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] Theta = (HalfPiQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] T1 = ((((Theta * Theta) >> 30) * Theta) >> 30) / 64'd6;
    localparam logic [63:0] S1 = (Theta >= T1) ? Theta - T1 : 64'd0;
    localparam logic [63:0] T2 = ((((T1 * Theta) >> 30) * Theta) >> 30) / 64'd20;
    localparam logic [63:0] S2 = S1 + T2;
    localparam logic [63:0] T3 = ((((T2 * Theta) >> 30) * Theta) >> 30) / 64'd42;
    localparam logic [63:0] S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
    localparam logic [63:0] T4 = ((((T3 * Theta) >> 30) * Theta) >> 30) / 64'd72;
    localparam logic [63:0] S4 = S3 + T4;
    localparam logic [63:0] T5 = ((((T4 * Theta) >> 30) * Theta) >> 30) / 64'd110;
    localparam logic [63:0] S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
    localparam logic [63:0] T6 = ((((T5 * Theta) >> 30) * Theta) >> 30) / 64'd156;
    localparam logic [63:0] S6 = S5 + T6;
    localparam logic [63:0] T7 = ((((T6 * Theta) >> 30) * Theta) >> 30) / 64'd210;
    localparam logic [63:0] S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
    localparam logic [63:0] Rounded = (S7 + 64'd16384) >> 15;
    localparam logic [63:0] Entry = (Rounded > 64'd32768) ? 64'd32768 : Rounded;
    assign sine_rom[k] = Entry[15:0];
  end

  // Sine lookup: quadrant and offset from the scaled phase, mirrored address.
  logic [ProdW-1:0]       sin_prod;
  logic [IdxW-1:0]        sin_idx;
  logic [IdxW-1:0]        sin_off;
  logic [IdxW-1:0]        sin_rem;
  logic [1:0]             sin_quad;
  logic [AddrW-1:0]       sin_addr;
  logic [15:0]            sin_mag;
  logic signed [AmpW-1:0] sin_amp;

  always_comb begin
    sin_prod = ProdW'(x_q) * ProdW'(4 * SINE_TABLE_DEPTH);
    sin_idx  = sin_prod[ProdW-1 -: IdxW];
    priority if (sin_idx >= IdxW'(3 * SINE_TABLE_DEPTH)) begin
      sin_quad = 2'd3;
      sin_off  = IdxW'(3 * SINE_TABLE_DEPTH);
    end else if (sin_idx >= IdxW'(2 * SINE_TABLE_DEPTH)) begin
      sin_quad = 2'd2;
      sin_off  = IdxW'(2 * SINE_TABLE_DEPTH);
    end else if (sin_idx >= IdxW'(SINE_TABLE_DEPTH)) begin
      sin_quad = 2'd1;
      sin_off  = IdxW'(SINE_TABLE_DEPTH);
    end else begin
      sin_quad = 2'd0;
      sin_off  = '0;
    end
    sin_rem  = sin_idx - sin_off;
    sin_addr = sin_quad[0] ? AddrW'(SINE_TABLE_DEPTH) - sin_rem[AddrW-1:0]
                           : sin_rem[AddrW-1:0];
    sin_mag  = sine_rom[sin_addr];
    // The positive peak saturates; the negative peak is exactly representable.
    if (sin_quad[1]) begin
      sin_amp = $signed(~sin_mag + 16'd1);
    end else if (sin_mag == 16'h8000) begin
      sin_amp = 16'sh7fff;
    end else begin
      sin_amp = $signed(sin_mag);
    end
  end

  // Linear shapes: floor((a*X + 2^14) / 2^15) + b * 32768.
  logic signed [34:0] x_s;
  logic signed [34:0] lin_t;
  logic signed [34:0] lin_sum;
  logic signed [19:0] lin_off;
  logic signed [19:0] lin_v;
  logic               x_lt_half;

  assign x_s       = $signed({5'b0, x_q});
  assign x_lt_half = !x_q[29];

  always_comb begin
    lin_t   = x_s <<< 1;
    lin_off = -20'sd32768;
    unique case (wave_shape_q)
      SHAPE_TRIANGLE: begin
        if (x_q[29:28] == 2'b00) begin
          lin_t   = x_s <<< 2;
          lin_off = 20'sd0;
        end else if (x_q[29:28] != 2'b11) begin
          lin_t   = -(x_s <<< 2);
          lin_off = 20'sd65536;
        end else begin
          lin_t   = x_s <<< 2;
          lin_off = -20'sd131072;
        end
      end
      SHAPE_MOOGSAW: begin
        if (x_lt_half) begin
          lin_t   = x_s <<< 2;
          lin_off = -20'sd32768;
        end else begin
          lin_t   = -(x_s <<< 1);
          lin_off = 20'sd32768;
        end
      end
      default: begin
        // Saw.
        lin_t   = x_s <<< 1;
        lin_off = -20'sd32768;
      end
    endcase
    lin_sum = lin_t + 35'sd16384;
    lin_v   = lin_sum[34:15] + lin_off;
  end

  // Quadratic shapes: one 30x30 product, scaled by 8 or 4, minus one.
  logic [30:0]        y_full;
  logic [29:0]        y;
  logic               x_gt_half;
  logic [29:0]        mul_a;
  logic [29:0]        mul_b;
  logic               scale4;
  logic [59:0]        quad_p;
  logic [60:0]        quad_sum;
  logic [18:0]        quad_mag;
  logic signed [19:0] quad_v;

  assign y_full    = 31'h4000_0000 - {1'b0, x_q};
  assign y         = y_full[29:0];
  assign x_gt_half = x_q > 30'h2000_0000;

  always_comb begin
    mul_a  = x_q;
    mul_b  = x_q;
    scale4 = 1'b0;
    unique case (wave_shape_q)
      SHAPE_MOOG: begin
        if (x_gt_half) begin
          mul_a  = y;
          mul_b  = y;
          scale4 = 1'b1;
        end
      end
      SHAPE_EXP: begin
        if (x_gt_half) begin
          mul_a = y;
          mul_b = y;
        end
      end
      SHAPE_EXPN: begin
        if (x_gt_half) begin
          mul_a = y;
        end
      end
      default: begin
        mul_a = x_q;
      end
    endcase
    quad_p   = 60'(mul_a) * 60'(mul_b);
    quad_sum = 61'(quad_p) + (scale4 ? Q4Bias : Q8Bias);
    quad_mag = scale4 ? {1'b0, quad_sum[60:43]} : quad_sum[60:42];
    quad_v   = $signed({1'b0, quad_mag}) - 20'sd32768;
  end

  // Shape select.
  logic signed [AmpW-1:0] amp_d;

  always_comb begin
    unique case (wave_shape_q)
      SHAPE_SINE:     amp_d = sin_amp;
      SHAPE_SQUARE:   amp_d = x_lt_half ? 16'sh7fff : 16'sh8000;
      SHAPE_TRIANGLE,
      SHAPE_SAW,
      SHAPE_MOOGSAW:  amp_d = sat16(lin_v);
      default:        amp_d = sat16(quad_v);
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      amp_q <= amp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign amplitude_o = amp_q;

endmodule

FILE: sv/mswg_checker.sv
// ----------------------------------------------------------------------------
// Waveform generator checker
// Port-level checks of the request flow through the generator pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mswg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [mswg_pkg::AmpW-1:0]   amplitude_o
);

  // A stalled result request keeps its value.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(amplitude_o), "stalled amplitude request changed")

  // A draining output always leaves room for a new phase request.
  `ASSERT_IMPLIES(a_ready_on_drain, clk_i, rst_ni, out_ready_i, in_ready_o, "input stalled while output drains")

  // An accepted phase passes x_q, then amp_q, to the output unless stalled.
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o, "accepted phase did not produce an amplitude")

endmodule

bind multi_shape_waveform_generator_core mswg_checker u_mswg_checker (.*);
